FILE: rtl/pun_pkg.sv
package pun_pkg;

	// Coordinate and fraction widths of the block.
	localparam int CW = 16;
	localparam int FB = 15;

	// Point differences, cross-product partial products and components.
	localparam int DW  = CW + 1;
	localparam int PW  = 2 * DW;
	localparam int CRW = PW + 1;
	localparam int MW  = CRW;

	// Split of a magnitude for squaring in narrow multipliers.
	localparam int LOW_W = (MW + 1) / 2;
	localparam int HI_W  = MW - LOW_W;

	// Sum of squares, root and root remainder.
	localparam int SW  = 2 * MW + 2;
	localparam int RW  = SW / 2;
	localparam int RMW = RW + 3;

	// Division remainder, quotient and output widths.
	localparam int DRW = RW + 1;
	localparam int QW  = FB + 1;
	localparam int OW  = 16;

	localparam int IN_TW  = ((9 * CW + 7) / 8) * 8;
	localparam int OUT_TW = ((3 * OW + 7) / 8) * 8;

	localparam logic [OW-1:0] OUT_MAX = {1'b0, {(OW - 1){1'b1}}};

	typedef logic [MW-1:0] mag_t;

	typedef struct packed {
		logic [2:0] neg;
		mag_t [2:0] mag;
	} side_t;

endpackage

FILE: rtl/plane_unit_normal_unit.sv
// Unit normal of a plane, Q1.15, from three points or two vectors.
//
// Input stream: one word per plane. tuser bit 0 selects the mode: 0 takes
// three points a, b, c and uses a-b and a-c; 1 takes a and b as vectors and
// ignores c. Output stream: one word per input word, in order, holding the
// normal components and a degenerate flag set when the cross product is
// zero (the normal is then zero).
//
// Seven stages form the cross product and its squared length, 36 stages take
// the square root one bit each, and 16 division stages plus the output
// register scale the three components. A new word is accepted in every cycle
// while the receiver is not stalling the output.
//
// The whole pipeline advances together whenever the output register is empty
// or being taken; while the receiver stalls with a word waiting, every stage
// holds and s_tready is low, so nothing is lost or repeated.
// Reset empties the pipeline; it holds no other state.
module plane_unit_normal_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from the lowest bit up.
	input  logic [pun_pkg::IN_TW-1:0]  s_tdata,
	// cmd.
	input  logic [0:0]                 s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// norm_x, norm_y, norm_z from the lowest bit up.
	output logic [pun_pkg::OUT_TW-1:0] m_tdata,
	// degenerate.
	output logic [0:0]                 m_tuser
);
	import pun_pkg::*;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic signed [CW-1:0] a [3];
	logic signed [CW-1:0] b [3];
	logic signed [CW-1:0] p [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a[i] = s_tdata[CW*i +: CW];
			b[i] = s_tdata[CW*(3+i) +: CW];
			p[i] = s_tdata[CW*(6+i) +: CW];
		end
	end

	logic signed [DW-1:0]  u_s1 [3];
	logic signed [DW-1:0]  w_s1 [3];
	logic signed [PW-1:0]  p_s2 [6];
	logic signed [CRW-1:0] c_s3 [3];
	logic [2:0]            neg_s4;
	mag_t                  mag_s4 [3];
	logic [2*HI_W-1:0]     hh_s5 [3];
	logic [HI_W+LOW_W-1:0] hl_s5 [3];
	logic [2*LOW_W-1:0]    ll_s5 [3];
	side_t                 side_s5;
	logic [SW-1:0]         sq_s6 [3];
	side_t                 side_s6;
	logic [SW-1:0]         sum_s7;
	side_t                 side_s7;
	logic                  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (s_tuser[0]) begin
					u_s1[i] <= DW'(a[i]);
					w_s1[i] <= DW'(b[i]);
				end else begin
					u_s1[i] <= DW'(a[i]) - DW'(b[i]);
					w_s1[i] <= DW'(a[i]) - DW'(p[i]);
				end
			end

			p_s2[0] <= u_s1[1] * w_s1[2];
			p_s2[1] <= u_s1[2] * w_s1[1];
			p_s2[2] <= u_s1[2] * w_s1[0];
			p_s2[3] <= u_s1[0] * w_s1[2];
			p_s2[4] <= u_s1[0] * w_s1[1];
			p_s2[5] <= u_s1[1] * w_s1[0];

			for (int i = 0; i < 3; i++) begin
				c_s3[i] <= CRW'(p_s2[2*i]) - CRW'(p_s2[2*i+1]);
			end

			for (int i = 0; i < 3; i++) begin
				neg_s4[i] <= c_s3[i][CRW-1];
				mag_s4[i] <= MW'(c_s3[i][CRW-1] ? -c_s3[i] : c_s3[i]);
			end

			// Square each magnitude as three narrow partial products.
			for (int i = 0; i < 3; i++) begin
				hh_s5[i] <= mag_s4[i][MW-1:LOW_W] * mag_s4[i][MW-1:LOW_W];
				hl_s5[i] <= mag_s4[i][MW-1:LOW_W] * mag_s4[i][LOW_W-1:0];
				ll_s5[i] <= mag_s4[i][LOW_W-1:0] * mag_s4[i][LOW_W-1:0];
				side_s5.mag[i] <= mag_s4[i];
			end
			side_s5.neg <= neg_s4;

			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= (SW'(hh_s5[i]) << (2 * LOW_W))
					+ (SW'(hl_s5[i]) << (LOW_W + 1)) + SW'(ll_s5[i]);
			end
			side_s6 <= side_s5;

			sum_s7  <= sq_s6[0] + sq_s6[1] + sq_s6[2];
			side_s7 <= side_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	logic          rt_valid;
	logic [RW-1:0] rt_root;
	side_t         rt_side;

	pun_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.in_sum    (sum_s7),
		.in_side   (side_s7),
		.out_valid (rt_valid),
		.out_root  (rt_root),
		.out_side  (rt_side)
	);

	logic [OW-1:0] norm [3];
	logic          degen;

	pun_div u_div (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.in_valid       (rt_valid),
		.in_len         (rt_root),
		.in_side        (rt_side),
		.out_valid      (m_tvalid),
		.out_norm       (norm),
		.out_degenerate (degen)
	);

	assign m_tdata    = OUT_TW'({norm[2], norm[1], norm[0]});
	assign m_tuser[0] = degen;

endmodule

FILE: rtl/pun_isqrt.sv
module pun_isqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [pun_pkg::SW-1:0] in_sum,
	input  pun_pkg::side_t         in_side,
	output logic                   out_valid,
	output logic [pun_pkg::RW-1:0] out_root,
	output pun_pkg::side_t         out_side
);
	import pun_pkg::*;

	logic [RMW-1:0] rem_q  [RW];
	logic [RW-1:0]  root_q [RW];
	logic [SW-1:0]  x_q    [RW];
	side_t          side_q [RW];
	logic [RW-1:0]  v_q;

	// One result bit per stage: bring down two bits of the radicand and try
	// the next root bit against the running remainder.
	for (genvar k = 0; k < RW; k++) begin : g_step
		logic [RMW-1:0] rem_i;
		logic [RW-1:0]  root_i;
		logic [SW-1:0]  x_i;
		side_t          side_i;
		logic           v_i;
		logic [RMW-1:0] cur;
		logic [RMW-1:0] trial;
		logic           take;

		if (k == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign x_i    = in_sum;
			assign side_i = in_side;
			assign v_i    = in_valid;
		end else begin : g_next
			assign rem_i  = rem_q[k-1];
			assign root_i = root_q[k-1];
			assign x_i    = x_q[k-1];
			assign side_i = side_q[k-1];
			assign v_i    = v_q[k-1];
		end

		assign cur   = {rem_i[RMW-3:0], x_i[SW-1-2*k -: 2]};
		assign trial = {1'b0, root_i, 2'b01};
		assign take  = (cur >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= take ? (cur - trial) : cur;
				root_q[k] <= {root_i[RW-2:0], take};
				x_q[k]    <= x_i;
				side_q[k] <= side_i;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= v_i;
			end
		end
	end

	assign out_valid = v_q[RW-1];
	assign out_root  = root_q[RW-1];
	assign out_side  = side_q[RW-1];

endmodule

FILE: rtl/pun_div.sv
module pun_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [pun_pkg::RW-1:0] in_len,
	input  pun_pkg::side_t         in_side,
	output logic                   out_valid,
	output logic [pun_pkg::OW-1:0] out_norm [3],
	output logic                   out_degenerate
);
	import pun_pkg::*;

	logic [DRW-1:0] r_q   [QW][3];
	logic [QW-1:0]  q_q   [QW][3];
	logic [RW-1:0]  len_q [QW];
	logic [2:0]     neg_q [QW];
	logic [QW-1:0]  v_q;

	logic           v_o_q;
	logic [OW-1:0]  norm_q [3];
	logic           degen_q;

	// Restoring division, one quotient bit per stage in each of three lanes.
	// The first stage yields the integer bit, since no component exceeds
	// the length.
	for (genvar j = 0; j < QW; j++) begin : g_step
		logic [DRW-1:0] r_i [3];
		logic [QW-1:0]  q_i [3];
		logic [RW-1:0]  len_i;
		logic [2:0]     neg_i;
		logic           v_i;

		if (j == 0) begin : g_first
			for (genvar l = 0; l < 3; l++) begin : g_lane
				assign r_i[l] = DRW'(in_side.mag[l]);
				assign q_i[l] = '0;
			end
			assign len_i = in_len;
			assign neg_i = in_side.neg;
			assign v_i   = in_valid;
		end else begin : g_next
			for (genvar l = 0; l < 3; l++) begin : g_lane
				assign r_i[l] = {r_q[j-1][l][DRW-2:0], 1'b0};
				assign q_i[l] = q_q[j-1][l];
			end
			assign len_i = len_q[j-1];
			assign neg_i = neg_q[j-1];
			assign v_i   = v_q[j-1];
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane_reg
			logic take;
			assign take = (r_i[l] >= DRW'(len_i));
			always_ff @(posedge clk) begin
				if (en) begin
					r_q[j][l] <= take ? (r_i[l] - DRW'(len_i)) : r_i[l];
					q_q[j][l] <= {q_i[l][QW-2:0], take};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				len_q[j] <= len_i;
				neg_q[j] <= neg_i;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[j] <= 1'b0;
			end else if (en) begin
				v_q[j] <= v_i;
			end
		end
	end

	// Clip, restore the sign and force zero for a degenerate plane.
	logic [OW-1:0] sat [3];
	logic          zero_len;

	assign zero_len = (len_q[QW-1] == '0);

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			sat[l] = (q_q[QW-1][l] > QW'(OUT_MAX)) ? OUT_MAX : OW'(q_q[QW-1][l]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				if (zero_len) begin
					norm_q[l] <= '0;
				end else begin
					norm_q[l] <= neg_q[QW-1][l] ? (OW'(0) - sat[l]) : sat[l];
				end
			end
			degen_q <= zero_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o_q <= 1'b0;
		end else if (en) begin
			v_o_q <= v_q[QW-1];
		end
	end

	assign out_valid      = v_o_q;
	assign out_norm       = norm_q;
	assign out_degenerate = degen_q;

endmodule
